// ----- hw/rtl/abscl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package abscl_pkg;

    // Defaults handed to the top-level parameters
    localparam int WINDOW_SAMPLES_DEF = 8;
    localparam int CHANNELS_DEF       = 4;

    // Fixed field widths
    localparam int SAMPLE_BITS  = 12;
    localparam int CHAN_BITS    = 2;
    localparam int CMD_BITS     = 2;
    localparam int STATE_BITS   = 2;
    localparam int STUCK_BITS   = 8;
    localparam int RMC_BITS     = 4;
    localparam int IN_DATA_W    = 16;
    localparam int IN_USER_W    = 2;
    localparam int OUT_DATA_W   = 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 12;

    // Queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register reset values
    localparam logic [11:0] FULL_SCALE_RST   = 12'd4095;
    localparam logic [11:0] HIGH_BAND_RST    = 12'd2457;
    localparam logic [11:0] LOW_BAND_RST     = 12'd1638;
    localparam logic [11:0] GROUND_RST       = 12'd446;
    localparam logic [7:0]  STUCK_LIMIT_RST  = 8'd20;
    localparam logic [3:0]  RELEASE_MIN_RST  = 4'd4;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ACTIVE_HIGH     = 3'd0,
        REG_LONG_PRESS_MODE = 3'd1,
        REG_FULL_SCALE      = 3'd2,
        REG_HIGH_BAND       = 3'd3,
        REG_LOW_BAND        = 3'd4,
        REG_GROUND          = 3'd5,
        REG_STUCK_LIMIT     = 3'd6,
        REG_RELEASE_MIN     = 3'd7
    } reg_idx_t;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_SAMPLE  = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2
    } cmd_t;

    typedef enum logic [STATE_BITS-1:0] {
        BTN_NOT_PRESSED = 2'd0,
        BTN_PRESSED     = 2'd1,
        BTN_RELEASED    = 2'd2,
        BTN_STUCK       = 2'd3
    } btn_state_t;

    typedef struct packed {
        logic                   active_high;
        logic                   long_press_mode;
        logic [SAMPLE_BITS-1:0] full_scale;
        logic [SAMPLE_BITS-1:0] high_band_threshold;
        logic [SAMPLE_BITS-1:0] low_band_threshold;
        logic [SAMPLE_BITS-1:0] ground_threshold;
        logic [STUCK_BITS-1:0]  stuck_limit;
        logic [RMC_BITS-1:0]    release_min_count;
    } cfg_t;

    // One decoded item on its way to the back end
    typedef struct packed {
        cmd_t                   cmd;
        logic [CHAN_BITS-1:0]   channel;
        logic [SAMPLE_BITS-1:0] sample;
        logic                   pressed;
    } item_t;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic out_pending;
    } back_stat_t;

    function automatic logic in_high_band(input logic [SAMPLE_BITS-1:0] s, input cfg_t c);
        return (s <= c.full_scale) && (s > c.high_band_threshold);
    endfunction

    // Level that drives the stuck counter
    function automatic logic in_pressed_band(input logic [SAMPLE_BITS-1:0] s, input cfg_t c);
        if (c.active_high)
            return in_high_band(s, c);
        return (s < c.ground_threshold) && (s != '0);
    endfunction

    // Window judgement of one stored sample: bit 0 high, bit 1 low
    function automatic logic [1:0] window_class(input logic [SAMPLE_BITS-1:0] s, input cfg_t c);
        logic hi;
        logic lo;
        if (c.active_high) begin
            hi = in_high_band(s, c);
            lo = !hi && (s < c.low_band_threshold);
        end
        else begin
            hi = (s < c.ground_threshold);
            lo = !hi && in_high_band(s, c);
        end
        return {lo, hi};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/analog_button_state_classifier_top.sv -----
// Channel  Dir  Width  Contents
// s_axis   in   16+2   tdata: channel[1:0], sample[13:2]; tuser: cmd[1:0]
// m_axis   out  8      tdata: out_channel[1:0], button_state[3:2]
// cfg      in   3+12   register index, write data; written when cfg_we is high
//
// The back end handles enable, disable, and samples that still fill the window while idle.
// A sample that triggers a judgement is stored, then each stored sample is read in turn
// on the single window memory read port, followed by a read drain step and a decide step.
// A 2-entry queue decouples input acceptance from the back end; the result register
// holds a finished beat until taken and stalls the decide step only while full.
// Reset clears all control and per-channel state; the window memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module analog_button_state_classifier_top
    import abscl_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
    parameter int CHANNELS       = CHANNELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // channel[1:0], sample[13:2]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // cmd[1:0]
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // out_channel[1:0], button_state[3:2]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t       cfg_reg;
    q_stat_t    q_stat;
    back_stat_t b_stat;
    item_t      push_item;
    item_t      head_item;
    logic       q_push;
    logic       q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.active_high         <= 1'b0;
            cfg_reg.long_press_mode     <= 1'b0;
            cfg_reg.full_scale          <= FULL_SCALE_RST;
            cfg_reg.high_band_threshold <= HIGH_BAND_RST;
            cfg_reg.low_band_threshold  <= LOW_BAND_RST;
            cfg_reg.ground_threshold    <= GROUND_RST;
            cfg_reg.stuck_limit         <= STUCK_LIMIT_RST;
            cfg_reg.release_min_count   <= RELEASE_MIN_RST;
        end
        else if (cfg_we) begin
            unique case (reg_idx_t'(cfg_addr))
                REG_ACTIVE_HIGH:     cfg_reg.active_high         <= cfg_wdata[0];
                REG_LONG_PRESS_MODE: cfg_reg.long_press_mode     <= cfg_wdata[0];
                REG_FULL_SCALE:      cfg_reg.full_scale          <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_HIGH_BAND:       cfg_reg.high_band_threshold <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_LOW_BAND:        cfg_reg.low_band_threshold  <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_GROUND:          cfg_reg.ground_threshold    <= cfg_wdata[SAMPLE_BITS-1:0];
                REG_STUCK_LIMIT:     cfg_reg.stuck_limit         <= cfg_wdata[STUCK_BITS-1:0];
                REG_RELEASE_MIN:     cfg_reg.release_min_count   <= cfg_wdata[RMC_BITS-1:0];
            endcase
        end
    end

    abscl_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg           (cfg_reg),
        .q_stat        (q_stat),
        .push          (q_push),
        .push_item     (push_item)
    );

    abscl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .stat      (q_stat)
    );

    abscl_back #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .CHANNELS       (CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_stat        (q_stat),
        .item          (head_item),
        .pop           (q_pop),
        .stat          (b_stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Queue level stays within its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    // Front never pushes into a full queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("push while queue full");

    // Back never pops an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop while queue empty");

    // A new result only comes out of a judgement in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(b_stat.busy))
        else $error("result without judgement");

endmodule

`default_nettype wire

// ----- hw/rtl/abscl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abscl_front
    import abscl_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [IN_DATA_W-1:0] s_axis_tdata,   // channel[1:0], sample[13:2]
    input  wire logic [IN_USER_W-1:0] s_axis_tuser,   // cmd[1:0]
    input  wire cfg_t                 cfg,
    input  wire q_stat_t              q_stat,
    output logic                      push,
    output item_t                     push_item
);

    logic                   keep;
    logic [CHAN_BITS-1:0]   channel;
    logic [SAMPLE_BITS-1:0] sample;
    cmd_t                   cmd;

    assign channel = s_axis_tdata[CHAN_BITS-1:0];
    assign sample  = s_axis_tdata[CHAN_BITS +: SAMPLE_BITS];
    assign cmd     = cmd_t'(s_axis_tuser[CMD_BITS-1:0]);

    // Drop unused command codes and channels beyond the configured count
    always_comb
    begin
        unique case (cmd)
            CMD_SAMPLE, CMD_ENABLE, CMD_DISABLE: keep = (int'(channel) < CHANNELS);
            default:                             keep = 1'b0;
        endcase
    end

    // Band check for the stuck counter is done here, ahead of the queue
    assign push_item.cmd     = cmd;
    assign push_item.channel = channel;
    assign push_item.sample  = sample;
    assign push_item.pressed = in_pressed_band(sample, cfg);

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && !q_stat.full && keep;

endmodule

`default_nettype wire

// ----- hw/rtl/abscl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abscl_queue
    import abscl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    input  wire logic  pop,
    output item_t      head_item,
    output q_stat_t    stat
);

    localparam logic [QPTR_W-1:0] LAST_PTR = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] DEPTH_CNT = QCNT_W'(QUEUE_DEPTH);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign head_item   = entry_reg[rd_ptr_reg];
    assign stat.empty  = (count_reg == '0);
    assign stat.full   = (count_reg == DEPTH_CNT);
    assign stat.count  = count_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/abscl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module abscl_back
    import abscl_pkg::*;
#(
    parameter int WINDOW_SAMPLES = WINDOW_SAMPLES_DEF,
    parameter int CHANNELS       = CHANNELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire q_stat_t               q_stat,
    input  wire item_t                 item,
    output logic                       pop,
    output back_stat_t                 stat,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata   // out_channel[1:0], button_state[3:2]
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int IDX_W = $clog2(WINDOW_SAMPLES);
    localparam int CNT_W = $clog2(WINDOW_SAMPLES + 1);
    localparam logic [IDX_W-1:0]      LAST_IDX = IDX_W'(WINDOW_SAMPLES - 1);
    localparam logic [CNT_W-1:0]      FULL_CNT = CNT_W'(WINDOW_SAMPLES);
    localparam logic [STUCK_BITS:0]   W_ONE    = (STUCK_BITS + 1)'(WINDOW_SAMPLES);
    localparam logic [STUCK_BITS:0]   W_TWO    = (STUCK_BITS + 1)'(2 * WINDOW_SAMPLES);
    localparam logic [STUCK_BITS-1:0] STUCK_MAX = '1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_DECIDE = 4'b1000
    } fsm_t;

    fsm_t                   state_reg;
    fsm_t                   state_next;
    logic [CH_W-1:0]        ch_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       hi_reg;
    logic [CNT_W-1:0]       lo_reg;
    logic                   rd_vld_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;

    // Per-channel state
    logic                   en_reg    [CHANNELS];
    logic [IDX_W-1:0]       fill_reg  [CHANNELS];
    logic [IDX_W-1:0]       wp_reg    [CHANNELS];
    logic [STUCK_BITS-1:0]  stuck_reg [CHANNELS];
    logic                   last_reg  [CHANNELS];

    // Sample window memory
    logic [SAMPLE_BITS-1:0] window_mem [CHANNELS][WINDOW_SAMPLES];

    logic [CH_W-1:0]        sel_ch;
    logic                   cur_en;
    logic [IDX_W-1:0]       cur_fill;
    logic [IDX_W-1:0]       cur_wp;
    logic [STUCK_BITS-1:0]  cur_stuck;
    logic                   cur_last;
    logic                   wr_sample;
    logic                   judge_start;
    logic                   out_free;
    logic                   load_out;
    logic [1:0]             cls;
    logic [STUCK_BITS-1:0]  lim;
    logic                   full;
    logic                   release_ok;
    btn_state_t             result;
    logic                   last_next;
    logic                   clr_stuck;

    // Per-channel state is read at one place: the head item, or the channel being judged
    assign sel_ch    = (state_reg == S_IDLE) ? CH_W'(item.channel) : ch_reg;
    assign cur_en    = en_reg[sel_ch];
    assign cur_fill  = fill_reg[sel_ch];
    assign cur_wp    = wp_reg[sel_ch];
    assign cur_stuck = stuck_reg[sel_ch];
    assign cur_last  = last_reg[sel_ch];

    assign pop         = (state_reg == S_IDLE) && !q_stat.empty;
    assign wr_sample   = pop && (item.cmd == CMD_SAMPLE) && cur_en;
    assign judge_start = wr_sample && (cur_fill == LAST_IDX);
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign load_out    = (state_reg == S_DECIDE) && out_free;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (judge_start) state_next = S_SCAN;
            S_SCAN:   if (idx_reg == LAST_IDX) state_next = S_DRAIN;
            S_DRAIN:  state_next = S_DECIDE;
            S_DECIDE: if (out_free) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // Window memory: write on sample, read one entry a cycle during the scan
    always_ff @(posedge clk)
    begin
        if (wr_sample)
            window_mem[sel_ch][cur_wp] <= item.sample;
        rd_data_reg <= window_mem[ch_reg][idx_reg];
    end

    assign cls = window_class(rd_data_reg, cfg);

    // Rules on the counted window
    assign lim        = cfg.stuck_limit - 1'b1;
    assign full       = (hi_reg == FULL_CNT);
    assign release_ok = (8'(lo_reg) > 8'(cfg.release_min_count)) && cur_last;

    always_comb
    begin
        result    = BTN_NOT_PRESSED;
        last_next = 1'b0;
        clr_stuck = 1'b0;
        if (!cfg.long_press_mode && full && (cur_stuck != lim)) begin
            result    = BTN_PRESSED;
            last_next = 1'b1;
        end
        else if (cfg.long_press_mode && full && ({1'b0, cur_stuck} == W_ONE)
                 && (cur_stuck < lim)) begin
            result = BTN_NOT_PRESSED;
        end
        else if (cfg.long_press_mode && full && ({1'b0, cur_stuck} >= W_TWO)
                 && (cur_stuck < lim)) begin
            result    = BTN_PRESSED;
            last_next = 1'b1;
        end
        else if (release_ok) begin
            result = BTN_RELEASED;
        end
        else if (full && (cur_stuck == lim)) begin
            result    = BTN_STUCK;
            clr_stuck = 1'b1;
        end
    end

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            idx_reg       <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg  <= state_next;
            rd_vld_reg <= (state_reg == S_SCAN);
            if (judge_start) begin
                ch_reg  <= sel_ch;
                idx_reg <= '0;
                hi_reg  <= '0;
                lo_reg  <= '0;
            end
            else begin
                if (state_reg == S_SCAN)
                    idx_reg <= idx_reg + 1'b1;
                if (rd_vld_reg) begin
                    hi_reg <= hi_reg + CNT_W'(cls[0]);
                    lo_reg <= lo_reg + CNT_W'(cls[1]);
                end
            end
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= {{(OUT_DATA_W - STATE_BITS - CHAN_BITS){1'b0}}, result,
                             CHAN_BITS'(ch_reg)};
    end

    // Per-channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                en_reg[i]    <= 1'b0;
                fill_reg[i]  <= '0;
                wp_reg[i]    <= '0;
                stuck_reg[i] <= '0;
                last_reg[i]  <= 1'b0;
            end
        end
        else begin
            if (pop) begin
                case (item.cmd)
                    CMD_ENABLE:  en_reg[sel_ch] <= 1'b1;
                    CMD_DISABLE:
                    begin
                        en_reg[sel_ch]   <= 1'b0;
                        fill_reg[sel_ch] <= '0;
                    end
                    default:
                    begin
                        if (wr_sample) begin
                            if (!item.pressed)
                                stuck_reg[sel_ch] <= '0;
                            else if (cur_stuck != STUCK_MAX)
                                stuck_reg[sel_ch] <= cur_stuck + 1'b1;
                            wp_reg[sel_ch] <= (cur_wp == LAST_IDX) ? '0 : cur_wp + 1'b1;
                            if (cur_fill != LAST_IDX)
                                fill_reg[sel_ch] <= cur_fill + 1'b1;
                        end
                    end
                endcase
            end
            if (load_out) begin
                last_reg[sel_ch] <= last_next;
                if (clr_stuck)
                    stuck_reg[sel_ch] <= '0;
            end
        end
    end

    assign m_axis_tvalid    = out_valid_reg;
    assign m_axis_tdata     = out_data_reg;
    assign stat.busy        = (state_reg != S_IDLE);
    assign stat.out_pending = out_valid_reg;

endmodule

`default_nettype wire

// ----- tb/abscl_checker.sv -----
`timescale 1ns / 1ps

// Watches the sample stream, the config port and the result stream of the
// button classifier, keeps its own copy of every channel and checks each result.
module abscl_checker
    import abscl_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // channel[1:0], sample[13:2]
    input  wire logic [IN_USER_W-1:0]  s_axis_tuser,   // cmd[1:0]
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // out_channel[1:0], button_state[3:2]
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                         mismatches,
    output int                         outstanding
);

    localparam int WIN = WINDOW_SAMPLES_DEF;
    localparam int NCH = CHANNELS_DEF;

    typedef struct packed {
        logic [CHAN_BITS-1:0] chan;
        btn_state_t           state;
    } verdict_t;

    cfg_t                   cfg_shadow;
    logic [SAMPLE_BITS-1:0] win_mem [NCH][WIN];
    int                     wr_ptr [NCH];
    int                     filled [NCH];
    logic                   armed [NCH];
    logic [STUCK_BITS-1:0]  stuck_run [NCH];
    logic                   was_pressed [NCH];
    verdict_t               verdict_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    function automatic logic high_band(input logic [SAMPLE_BITS-1:0] v);
        return (v > cfg_shadow.high_band_threshold) && (v <= cfg_shadow.full_scale);
    endfunction

    // Update one channel for an accepted beat; queue the verdict if one is due
    task automatic classify_beat(input logic [CMD_BITS-1:0] cmd,
                                 input logic [CHAN_BITS-1:0] ch,
                                 input logic [SAMPLE_BITS-1:0] s);
        logic [SAMPLE_BITS-1:0] v;
        logic [STUCK_BITS-1:0]  lim;
        logic                   in_press;
        logic                   full;
        logic                   rel;
        int                     hi_n;
        int                     lo_n;
        int                     sc;
        btn_state_t             st;
        case (cmd)
            CMD_ENABLE: armed[ch] = 1'b1;
            CMD_DISABLE:
            begin
                armed[ch]  = 1'b0;
                filled[ch] = 0;
            end
            CMD_SAMPLE:
            begin
                if (armed[ch])
                begin
                    // stuck counter follows the pressed level, saturating
                    if (cfg_shadow.active_high)
                        in_press = high_band(s);
                    else
                        in_press = (s < cfg_shadow.ground_threshold) && (s != '0);
                    if (!in_press)
                        stuck_run[ch] = '0;
                    else if (stuck_run[ch] != '1)
                        stuck_run[ch] = stuck_run[ch] + 1'b1;

                    win_mem[ch][wr_ptr[ch]] = s;
                    wr_ptr[ch] = (wr_ptr[ch] + 1) % WIN;

                    if (filled[ch] < WIN - 1)
                        filled[ch]++;
                    else
                    begin
                        // count high and low levels over the window
                        hi_n = 0;
                        lo_n = 0;
                        for (int k = 0; k < WIN; k++)
                        begin
                            v = win_mem[ch][k];
                            if (cfg_shadow.active_high)
                            begin
                                if (high_band(v))
                                    hi_n++;
                                else if (v < cfg_shadow.low_band_threshold)
                                    lo_n++;
                            end
                            else
                            begin
                                if (v < cfg_shadow.ground_threshold)
                                    hi_n++;
                                else if (high_band(v))
                                    lo_n++;
                            end
                        end
                        full = (hi_n == WIN);
                        rel  = (lo_n > int'(cfg_shadow.release_min_count)) && was_pressed[ch];
                        lim  = cfg_shadow.stuck_limit - 8'd1;
                        sc   = int'(stuck_run[ch]);

                        // rule priority: press rules, release, stuck, idle
                        if (!cfg_shadow.long_press_mode && full && sc != int'(lim))
                            st = BTN_PRESSED;
                        else if (cfg_shadow.long_press_mode && full && sc == WIN
                                 && sc < int'(lim))
                            st = BTN_NOT_PRESSED;
                        else if (cfg_shadow.long_press_mode && full && sc >= 2 * WIN
                                 && sc < int'(lim))
                            st = BTN_PRESSED;
                        else if (rel)
                            st = BTN_RELEASED;
                        else if (full && sc == int'(lim))
                        begin
                            st = BTN_STUCK;
                            stuck_run[ch] = '0;
                        end
                        else
                            st = BTN_NOT_PRESSED;
                        was_pressed[ch] = (st == BTN_PRESSED);
                        verdict_q.push_back('{chan: ch, state: st});
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : track
        verdict_t want;
        if (!rst_n)
        begin
            cfg_shadow.active_high         = 1'b0;
            cfg_shadow.long_press_mode     = 1'b0;
            cfg_shadow.full_scale          = FULL_SCALE_RST;
            cfg_shadow.high_band_threshold = HIGH_BAND_RST;
            cfg_shadow.low_band_threshold  = LOW_BAND_RST;
            cfg_shadow.ground_threshold    = GROUND_RST;
            cfg_shadow.stuck_limit         = STUCK_LIMIT_RST;
            cfg_shadow.release_min_count   = RELEASE_MIN_RST;
            for (int c = 0; c < NCH; c++)
            begin
                wr_ptr[c]      = 0;
                filled[c]      = 0;
                armed[c]       = 1'b0;
                stuck_run[c]   = '0;
                was_pressed[c] = 1'b0;
                for (int k = 0; k < WIN; k++)
                    win_mem[c][k] = '0;
            end
            verdict_q.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // register writes
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_addr))
                    REG_ACTIVE_HIGH:     cfg_shadow.active_high         = cfg_wdata[0];
                    REG_LONG_PRESS_MODE: cfg_shadow.long_press_mode     = cfg_wdata[0];
                    REG_FULL_SCALE:      cfg_shadow.full_scale          = cfg_wdata;
                    REG_HIGH_BAND:       cfg_shadow.high_band_threshold = cfg_wdata;
                    REG_LOW_BAND:        cfg_shadow.low_band_threshold  = cfg_wdata;
                    REG_GROUND:          cfg_shadow.ground_threshold    = cfg_wdata;
                    REG_STUCK_LIMIT:     cfg_shadow.stuck_limit = cfg_wdata[STUCK_BITS-1:0];
                    REG_RELEASE_MIN:     cfg_shadow.release_min_count = cfg_wdata[RMC_BITS-1:0];
                    default: ;
                endcase
            end

            // result beat against the oldest verdict
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (verdict_q.size() == 0)
                    report_mismatch($sformatf("unexpected result beat %h", m_axis_tdata));
                else
                begin
                    want = verdict_q.pop_front();
                    if (m_axis_tdata[1:0] != want.chan)
                        report_mismatch($sformatf("out_channel %0d, want %0d",
                                                  m_axis_tdata[1:0], want.chan));
                    if (m_axis_tdata[3:2] != want.state)
                        report_mismatch($sformatf("ch %0d button_state %0d, want %0d",
                                                  want.chan, m_axis_tdata[3:2], want.state));
                end
            end

            // input beat
            if (s_axis_tvalid && s_axis_tready)
                classify_beat(s_axis_tuser, s_axis_tdata[1:0], s_axis_tdata[13:2]);

            outstanding <= verdict_q.size();
        end
    end

endmodule

// ----- tb/analog_button_state_classifier_top_tb.sv -----
`timescale 1ns / 1ps

module analog_button_state_classifier_top_tb;
    import abscl_pkg::*;

    localparam logic [CMD_BITS-1:0] CMD_RESERVED = 2'd3;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int FIXED_PHASES    = 8;
    localparam int RANDOM_PHASES   = 2;
    localparam int SETTLE_CYCLES   = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    int   mismatches;
    int   outstanding;
    logic steady = 1'b0;       // no idling on either side while set
    cfg_t stim_cfg;
    logic chan_on [CHANNELS_DEF];
    int   beats_sent;

    always #5 clk = ~clk;

    analog_button_state_classifier_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    abscl_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // Result side back-pressure
    always @(posedge clk)
        m_axis_tready <= steady || ($urandom_range(99) >= 21);

    // Hard stop
    initial
    begin
        #2_000_000;
        $display("** analog_button_state_classifier_top: FAILED **");
        $finish;
    end

    // One input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic [CMD_BITS-1:0] cmd,
                             input logic [CHAN_BITS-1:0] ch,
                             input logic [SAMPLE_BITS-1:0] s);
        while (!steady && $urandom_range(99) < 21)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, s, ch};
        s_axis_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (cmd == CMD_ENABLE)
            chan_on[ch] = 1'b1;
        else if (cmd == CMD_DISABLE)
            chan_on[ch] = 1'b0;
        beats_sent++;
    endtask

    // Stop sending and let every expected result and queued item drain
    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_cfg(input cfg_t c);
        reg_idx_t                idx;
        logic [CFG_DATA_W-1:0]   val;
        for (int r = 0; r < 8; r++)
        begin
            idx = reg_idx_t'(r);
            case (idx)
                REG_ACTIVE_HIGH:     val = CFG_DATA_W'(c.active_high);
                REG_LONG_PRESS_MODE: val = CFG_DATA_W'(c.long_press_mode);
                REG_FULL_SCALE:      val = c.full_scale;
                REG_HIGH_BAND:       val = c.high_band_threshold;
                REG_LOW_BAND:        val = c.low_band_threshold;
                REG_GROUND:          val = c.ground_threshold;
                REG_STUCK_LIMIT:     val = CFG_DATA_W'(c.stuck_limit);
                default:             val = CFG_DATA_W'(c.release_min_count);
            endcase
            cfg_we    <= 1'b1;
            cfg_addr  <= idx;
            cfg_wdata <= val;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        stim_cfg = c;
    endtask

    function automatic cfg_t make_cfg(input logic ah, input logic lp,
                                      input int fs, input int hb, input int lb,
                                      input int gnd, input int sl, input int rmc);
        cfg_t c;
        c.active_high         = ah;
        c.long_press_mode     = lp;
        c.full_scale          = SAMPLE_BITS'(fs);
        c.high_band_threshold = SAMPLE_BITS'(hb);
        c.low_band_threshold  = SAMPLE_BITS'(lb);
        c.ground_threshold    = SAMPLE_BITS'(gnd);
        c.stuck_limit         = STUCK_BITS'(sl);
        c.release_min_count   = RMC_BITS'(rmc);
        return c;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] any_sample();
        return SAMPLE_BITS'($urandom_range(4095, 0));
    endfunction

    // Sample inside the high band, or anything when the band is empty
    function automatic logic [SAMPLE_BITS-1:0] band_sample();
        if (stim_cfg.high_band_threshold < stim_cfg.full_scale)
            return SAMPLE_BITS'($urandom_range(stim_cfg.full_scale,
                                               stim_cfg.high_band_threshold + 1));
        return any_sample();
    endfunction

    // Level a pressed button shows on the line
    function automatic logic [SAMPLE_BITS-1:0] pressed_sample();
        if (stim_cfg.active_high)
            return band_sample();
        if ($urandom_range(99) < 5)
            return '0;
        if (stim_cfg.ground_threshold >= 2)
            return SAMPLE_BITS'($urandom_range(stim_cfg.ground_threshold - 1, 1));
        return any_sample();
    endfunction

    // Level a released button shows on the line
    function automatic logic [SAMPLE_BITS-1:0] released_sample();
        if (!stim_cfg.active_high)
            return band_sample();
        if (stim_cfg.low_band_threshold >= 1)
            return SAMPLE_BITS'($urandom_range(stim_cfg.low_band_threshold - 1, 0));
        return any_sample();
    endfunction

    // Mostly press/release episodes on one channel, with noise and stray items
    task automatic run_phase(input int quota);
        int                   start;
        int                   roll;
        int                   n_press;
        int                   n_rel;
        logic [CHAN_BITS-1:0] ch;
        start = beats_sent;
        while (beats_sent - start < quota)
        begin
            ch = CHAN_BITS'($urandom_range(CHANNELS_DEF - 1, 0));
            if (!chan_on[ch] && $urandom_range(9) != 0)
                send_beat(CMD_ENABLE, ch, any_sample());
            roll = $urandom_range(99);
            if (roll < 72)
            begin
                case ($urandom_range(2, 0))
                    0: n_press = $urandom_range(8, 1);
                    1: n_press = $urandom_range(24, 8);
                    default:
                        if (stim_cfg.stuck_limit > 1 && stim_cfg.stuck_limit < 40)
                            n_press = stim_cfg.stuck_limit + $urandom_range(3, 0);
                        else
                            n_press = $urandom_range(40, 16);
                endcase
                n_rel = $urandom_range(12, 0);
                for (int i = 0; i < n_press + n_rel; i++)
                begin
                    if ($urandom_range(99) < 6)
                        send_beat(CMD_SAMPLE,
                                  CHAN_BITS'($urandom_range(CHANNELS_DEF - 1, 0)),
                                  any_sample());
                    else if ($urandom_range(99) < 5)
                        send_beat(CMD_SAMPLE, ch, any_sample());
                    else if (i < n_press)
                        send_beat(CMD_SAMPLE, ch, pressed_sample());
                    else
                        send_beat(CMD_SAMPLE, ch, released_sample());
                end
            end
            else if (roll < 84)
            begin
                repeat ($urandom_range(8, 1))
                    send_beat(CMD_SAMPLE, ch, any_sample());
            end
            else if (roll < 92)
            begin
                send_beat(CMD_DISABLE, ch, any_sample());
                if ($urandom_range(1, 0))
                    send_beat(CMD_SAMPLE, ch, any_sample());
            end
            else if (roll < 96)
                send_beat(CMD_RESERVED, ch, any_sample());
            else
                send_beat(CMD_ENABLE, ch, any_sample());
        end
    endtask

    initial
    begin
        cfg_t phase_cfg [FIXED_PHASES];
        cfg_t rnd;
        int   hb;

        beats_sent = 0;
        for (int c = 0; c < CHANNELS_DEF; c++)
            chan_on[c] = 1'b0;
        stim_cfg = make_cfg(1'b0, 1'b0, FULL_SCALE_RST, HIGH_BAND_RST, LOW_BAND_RST,
                            GROUND_RST, STUCK_LIMIT_RST, RELEASE_MIN_RST);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, active low, short press rules
        send_beat(CMD_SAMPLE, 2'd2, 12'd777);          // channel still disabled
        send_beat(CMD_RESERVED, 2'd1, 12'hFFF);        // unused command code
        for (int c = 0; c < CHANNELS_DEF; c++)
            send_beat(CMD_ENABLE, CHAN_BITS'(c), 12'h000);
        // band edges on channel 0; the last two samples are judged
        send_beat(CMD_SAMPLE, 2'd0, 12'd0);
        send_beat(CMD_SAMPLE, 2'd0, 12'd4095);
        send_beat(CMD_SAMPLE, 2'd0, 12'd1);
        send_beat(CMD_SAMPLE, 2'd0, 12'd445);
        send_beat(CMD_SAMPLE, 2'd0, 12'd446);
        send_beat(CMD_SAMPLE, 2'd0, 12'd2457);
        send_beat(CMD_SAMPLE, 2'd0, 12'd2458);
        send_beat(CMD_SAMPLE, 2'd0, 12'd1637);
        send_beat(CMD_SAMPLE, 2'd0, 12'd1638);
        send_beat(CMD_ENABLE, 2'd0, 12'h555);           // already enabled
        send_beat(CMD_DISABLE, 2'd3, 12'hAAA);
        send_beat(CMD_SAMPLE, 2'd3, 12'd4095);         // dropped while disabled
        // full window at the pressed level on channel 1
        repeat (8)
            send_beat(CMD_SAMPLE, 2'd1, 12'd100);
        wait_quiet();

        // Fixed settings: defaults mirrored, extremes of most registers
        phase_cfg[0] = make_cfg(1'b1, 1'b0, 4095, 2457, 1638, 446, 20, 4);
        phase_cfg[1] = make_cfg(1'b0, 1'b1, 4095, 2457, 1638, 446, 40, 0);
        phase_cfg[2] = make_cfg(1'b1, 1'b1, 4095, 2000, 1000, 446, 255, 8);
        phase_cfg[3] = make_cfg(1'b0, 1'b0, 4095, 2457, 1638, 600, 1, 2);
        phase_cfg[4] = make_cfg(1'b1, 1'b0, 0, 0, 4095, 4095, 10, 0);
        phase_cfg[5] = make_cfg(1'b0, 1'b1, 4095, 0, 0, 0, 0, 3);
        phase_cfg[6] = make_cfg(1'b1, 1'b1, 4095, 4094, 1, 446, 30, 1);
        phase_cfg[7] = make_cfg(1'b0, 1'b0, 4095, 3000, 2000, 4095, 12, 8);

        for (int p = 0; p < FIXED_PHASES; p++)
        begin
            program_cfg(phase_cfg[p]);
            steady = (p == 2);
            run_phase(ITEMS_PER_PHASE);
            steady = 1'b0;
            wait_quiet();
        end

        // Random but sensible settings
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            hb  = $urandom_range(3500, 1000);
            rnd = make_cfg($urandom_range(1, 0), $urandom_range(1, 0),
                           $urandom_range(4095, hb), hb, $urandom_range(hb, 0),
                           $urandom_range(1500, 1), $urandom_range(48, 9),
                           $urandom_range(8, 0));
            program_cfg(rnd);
            run_phase(ITEMS_PER_PHASE);
            wait_quiet();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("** analog_button_state_classifier_top: PASSED **");
        else
            $display("** analog_button_state_classifier_top: FAILED **");
        $finish;
    end

endmodule
